### design/palette_pixel_unpacker_macros.svh
// assertion macros for the palette pixel unpacker
// used by the top level only; no other dependencies
`ifndef PALETTE_PIXEL_UNPACKER_MACROS_SVH
`define PALETTE_PIXEL_UNPACKER_MACROS_SVH

// condition holds in the same cycle
`define PPU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// condition holds in the next cycle
`define PPU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/ppu_pkg.sv
// shared types and codes for the palette pixel unpacker
// no dependencies
`timescale 1ns / 1ps

package ppu_pkg;

   localparam int PAL_DEPTH = 256;
   localparam int PAL_AW    = 8;
   localparam int COMP_W    = 8;
   localparam int COLOUR_W  = 24;

   // transaction actions
   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_WORD   = 2'd1;
   localparam logic [1:0] ACT_BORDER = 2'd2;

   // register write selectors, data bits 31:28
   localparam logic [3:0] REG_PALETTE = 4'h0;
   localparam logic [3:0] REG_POINTER = 4'h1;
   localparam logic [3:0] REG_BORDER  = 4'h4;
   localparam logic [3:0] REG_MODE    = 4'he;

   localparam logic [31:0] POINTER_RSVD_MASK = 32'h0fffff00;
   localparam logic [31:0] MODE_RSVD_MASK    = 32'h0ff00000;

   // pixel modes
   localparam logic [2:0] MODE_1BPP  = 3'd0;
   localparam logic [2:0] MODE_2BPP  = 3'd1;
   localparam logic [2:0] MODE_4BPP  = 3'd2;
   localparam logic [2:0] MODE_8BPP  = 3'd3;
   localparam logic [2:0] MODE_16BPP = 3'd4;
   localparam logic [2:0] MODE_32BPP = 3'd6;

   typedef struct packed {
      logic                en;
      logic [PAL_AW-1:0]   addr;
      logic [COLOUR_W-1:0] data;
   } ppu_wr_type;

   typedef struct packed {
      logic [PAL_AW-1:0] red;
      logic [PAL_AW-1:0] green;
      logic [PAL_AW-1:0] blue;
   } ppu_addr_type;

   // one pixel leaving the sequencer
   typedef struct packed {
      logic                issue;
      logic                last;
      logic                bad;
      logic                use_ram;
      logic [COLOUR_W-1:0] colour;
   } ppu_tag_type;

endpackage

### design/ppu_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ppu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/ppu_seq.sv
// front sequencer: holds one transaction, applies register writes and
// steps a video word into one palette lookup per cycle while advance is high; uses ppu_pkg
`timescale 1ns / 1ps

module ppu_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_action,
   input  logic [31:0]           req_data,
   input  logic                  advance,
   output ppu_pkg::ppu_tag_type  tag,
   output ppu_pkg::ppu_addr_type rd_addr,
   output ppu_pkg::ppu_wr_type   wr
);
   import ppu_pkg::*;

   logic                s0_valid_ff, s0_valid_in;
   logic [1:0]          s0_action_ff, s0_action_in;
   logic [31:0]         s0_data_ff, s0_data_in;
   logic [4:0]          s0_index_ff, s0_index_in;
   logic [PAL_AW-1:0]   pointer_ff, pointer_in;
   logic [COLOUR_W-1:0] border_ff, border_in;
   logic [2:0]          mode_ff, mode_in;

   logic [3:0]  nibble;
   logic [4:0]  last_idx;
   logic [31:0] data_shifted;
   logic        is_pixel;
   logic        last_pix;
   logic        issue;
   logic        done_now;
   logic        bad;

   always_comb begin
      nibble       = s0_data_ff[31:28];
      last_idx     = 5'd0;
      data_shifted = s0_data_ff;
      bad          = 1'b0;
      rd_addr      = '{red: s0_data_ff[7:0], green: s0_data_ff[7:0],
                       blue: s0_data_ff[7:0]};
      unique case (mode_ff)
         MODE_1BPP: begin
            last_idx     = 5'd31;
            data_shifted = {1'b0, s0_data_ff[31:1]};
            rd_addr      = '{red: {7'd0, s0_data_ff[0]}, green: {7'd0, s0_data_ff[0]},
                             blue: {7'd0, s0_data_ff[0]}};
         end
         MODE_2BPP: begin
            last_idx     = 5'd15;
            data_shifted = {2'd0, s0_data_ff[31:2]};
            rd_addr      = '{red: {6'd0, s0_data_ff[1:0]}, green: {6'd0, s0_data_ff[1:0]},
                             blue: {6'd0, s0_data_ff[1:0]}};
         end
         MODE_4BPP: begin
            last_idx     = 5'd7;
            data_shifted = {4'd0, s0_data_ff[31:4]};
            rd_addr      = '{red: {4'd0, s0_data_ff[3:0]}, green: {4'd0, s0_data_ff[3:0]},
                             blue: {4'd0, s0_data_ff[3:0]}};
         end
         MODE_8BPP: begin
            last_idx     = 5'd3;
            data_shifted = {8'd0, s0_data_ff[31:8]};
         end
         MODE_16BPP: begin
            last_idx     = 5'd1;
            data_shifted = {16'd0, s0_data_ff[31:16]};
            rd_addr      = '{red: s0_data_ff[7:0], green: s0_data_ff[11:4],
                             blue: s0_data_ff[15:8]};
         end
         MODE_32BPP: begin
            rd_addr      = '{red: s0_data_ff[7:0], green: s0_data_ff[15:8],
                             blue: s0_data_ff[23:16]};
         end
         default: begin
            bad = 1'b1;
         end
      endcase
   end

   assign is_pixel  = (s0_action_ff == ACT_WORD) || (s0_action_ff == ACT_BORDER);
   assign last_pix  = (s0_action_ff == ACT_BORDER) || (s0_index_ff == last_idx);
   assign issue     = s0_valid_ff && is_pixel && advance;
   assign done_now  = s0_valid_ff && (!is_pixel || (advance && last_pix));
   assign req_ready = !s0_valid_ff || done_now;

   always_comb begin
      tag.issue   = issue;
      tag.last    = last_pix;
      tag.bad     = 1'b0;
      tag.use_ram = 1'b0;
      tag.colour  = border_ff;
      if (s0_action_ff == ACT_WORD) begin
         tag.bad     = bad;
         tag.use_ram = !bad;
         tag.colour  = '0;
      end
   end

   // register writes take effect while the transaction sits here
   always_comb begin
      wr.en      = 1'b0;
      wr.addr    = pointer_ff;
      wr.data    = s0_data_ff[COLOUR_W-1:0];
      pointer_in = pointer_ff;
      border_in  = border_ff;
      mode_in    = mode_ff;
      if (s0_valid_ff && (s0_action_ff == ACT_WRITE)) begin
         unique case (nibble)
            REG_PALETTE: begin
               wr.en      = 1'b1;
               pointer_in = pointer_ff + 1'b1;
            end
            REG_POINTER: begin
               if ((s0_data_ff & POINTER_RSVD_MASK) == '0) begin
                  pointer_in = s0_data_ff[PAL_AW-1:0];
               end
            end
            REG_BORDER: begin
               border_in = s0_data_ff[COLOUR_W-1:0];
            end
            REG_MODE: begin
               if ((s0_data_ff & MODE_RSVD_MASK) == '0) begin
                  mode_in = s0_data_ff[7:5];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s0_valid_in  = s0_valid_ff;
      s0_action_in = s0_action_ff;
      s0_data_in   = s0_data_ff;
      s0_index_in  = s0_index_ff;
      if (req_ready) begin
         s0_valid_in  = req_valid;
         s0_action_in = req_action;
         s0_data_in   = req_data;
         s0_index_in  = 5'd0;
      end else if (issue) begin
         s0_data_in  = data_shifted;
         s0_index_in = s0_index_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         pointer_ff  <= '0;
         border_ff   <= '0;
         mode_ff     <= MODE_1BPP;
      end else begin
         s0_valid_ff <= s0_valid_in;
         pointer_ff  <= pointer_in;
         border_ff   <= border_in;
         mode_ff     <= mode_in;
      end
      s0_action_ff <= s0_action_in;
      s0_data_ff   <= s0_data_in;
      s0_index_ff  <= s0_index_in;
   end

endmodule

### design/palette_pixel_unpacker.sv
// top level of the palette pixel unpacker: sequencer, three palette byte
// lanes, lookup stage and output register; uses ppu_pkg, ppu_seq, ppu_ram
//
//  channel   direction  ports                                      handshake
//  req_      in         req_action, req_data                       req_valid / req_ready
//  rsp_      out        rsp_red/green/blue, rsp_last, rsp_bad_mode rsp_valid / rsp_ready
//
// one pixel per cycle unless rsp_ready stalls the output, set by the single read
// port of each palette byte lane; a video word gives 32, 16, 8, 4, 2 or 1 pixels by
// mode; register writes and unused actions give no pixel, a border action gives one
// the first pixel passes through the lookup stage and the output register to rsp_
// reset clears pointer, border colour, mode and all valid flags; the palette
// itself is not cleared
// rsp_ready low stalls the lookup stage, then the sequencer, then req_ready
`timescale 1ns / 1ps
`include "palette_pixel_unpacker_macros.svh"

module palette_pixel_unpacker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last,
   output logic        rsp_bad_mode
);
   import ppu_pkg::*;

   ppu_tag_type  tag;
   ppu_addr_type rd_addr;
   ppu_wr_type   wr;

   logic [COMP_W-1:0] red_rd, green_rd, blue_rd;

   // lookup stage, waits on the ram read
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_last_ff;
   logic                s1_bad_ff;
   logic                s1_use_ram_ff;
   logic [COLOUR_W-1:0] s1_colour_ff;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLOUR_W-1:0] rsp_colour_ff;
   logic                rsp_last_ff;
   logic                rsp_bad_ff;

   logic                out_free;
   logic                advance;
   logic [COLOUR_W-1:0] s1_pixel;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = !s1_valid_ff || out_free;

   ppu_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .req_data   (req_data),
      .advance    (advance),
      .tag        (tag),
      .rd_addr    (rd_addr),
      .wr         (wr)
   );

   // one lane per colour component so all three lookups run in the same cycle;
   // every palette write lands in all lanes
   ppu_ram #(.WIDTH(COMP_W), .DEPTH(PAL_DEPTH)) u_ram_red (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data[COMP_W-1:0]),
      .rd_en   (tag.issue),
      .rd_addr (rd_addr.red),
      .rd_data (red_rd)
   );

   ppu_ram #(.WIDTH(COMP_W), .DEPTH(PAL_DEPTH)) u_ram_green (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data[2*COMP_W-1:COMP_W]),
      .rd_en   (tag.issue),
      .rd_addr (rd_addr.green),
      .rd_data (green_rd)
   );

   ppu_ram #(.WIDTH(COMP_W), .DEPTH(PAL_DEPTH)) u_ram_blue (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data[3*COMP_W-1:2*COMP_W]),
      .rd_en   (tag.issue),
      .rd_addr (rd_addr.blue),
      .rd_data (blue_rd)
   );

   // ram output holds while stalled since no read is issued then
   assign s1_pixel = s1_use_ram_ff ? {blue_rd, green_rd, red_rd} : s1_colour_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (advance) begin
         s1_valid_in = tag.issue;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         s1_last_ff    <= tag.last;
         s1_bad_ff     <= tag.bad;
         s1_use_ram_ff <= tag.use_ram;
         s1_colour_ff  <= tag.colour;
      end
      if (out_free && s1_valid_ff) begin
         rsp_colour_ff <= s1_pixel;
         rsp_last_ff   <= s1_last_ff;
         rsp_bad_ff    <= s1_bad_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_red      = rsp_colour_ff[COMP_W-1:0];
   assign rsp_green    = rsp_colour_ff[2*COMP_W-1:COMP_W];
   assign rsp_blue     = rsp_colour_ff[3*COMP_W-1:2*COMP_W];
   assign rsp_last     = rsp_last_ff;
   assign rsp_bad_mode = rsp_bad_ff;

   // a stalled lookup must keep its pixel
   `PPU_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !out_free, s1_valid_ff)
   // palette writes never coincide with a lookup
   `PPU_ASSERT_NOW(a_wr_no_read, clock, reset, wr.en, !tag.issue)
   // an unsupported mode gives a single black, final pixel
   `PPU_ASSERT_NOW(a_bad_black, clock, reset, rsp_valid_ff && rsp_bad_ff, rsp_last_ff && (rsp_colour_ff == '0))

endmodule
